@@ sv/tsc_pkg.sv @@
// Shared types and constants for the timestamp sync checker.
`default_nettype none

package tsc_pkg;

   // Event kind carried with each beat.
   typedef enum logic {
      FUNC_IMU = 1'b0,
      FUNC_CAM = 1'b1
   } func_type;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 4'd1;

   localparam int CSR_DATA_W = 32;
   localparam int TOL_W      = 32;
   localparam int WIN_CFG_W  = 12;

   localparam logic [TOL_W-1:0]     TOL_RESET = 32'd5000000;
   localparam logic [WIN_CFG_W-1:0] WIN_RESET = 12'd2000;

   // Command queue between the front and back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // Head-of-queue status seen by the back end.
   typedef struct packed {
      logic     valid;
      func_type func;
   } q_stat_type;

endpackage : tsc_pkg

`default_nettype wire

@@ sv/tsc_front.sv @@
// Front end: accepts event beats, tags their kind and queues them for the back end.
`default_nettype none

module tsc_front
   import tsc_pkg::*;
#(
   parameter int STAMP_BITS = 63
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_func,
   input  wire logic [STAMP_BITS-1:0] req_stamp_ns,
   input  wire logic                  q_pop,
   output q_stat_type                 q_stat,
   output logic [STAMP_BITS-1:0]      q_stamp
);

   logic [STAMP_BITS:0] entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]  count_ff, count_in;
   logic                push;
   logic                pop;
   logic                full;
   func_type            beat_func;

   // A beat is taken whenever the queue has a free slot.
   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign busy      = full;
   assign push      = start && !full;
   assign pop       = q_pop && (count_ff != '0);
   assign beat_func = req_func ? FUNC_CAM : FUNC_IMU;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {beat_func, req_stamp_ns};
      end
   end

   // Show-ahead head of the queue.
   assign q_stat.valid = (count_ff != '0);
   assign q_stat.func  = entry_ff[rd_ptr_ff][STAMP_BITS] ? FUNC_CAM : FUNC_IMU;
   assign q_stamp      = entry_ff[rd_ptr_ff][STAMP_BITS-1:0];

endmodule : tsc_front

`default_nettype wire

@@ sv/tsc_back.sv @@
// Back end: stamp ring, bisection search over the window and offset statistics.
`default_nettype none

module tsc_back
   import tsc_pkg::*;
#(
   parameter int RING_DEPTH = 2048,
   parameter int STAMP_BITS = 63
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire q_stat_type            q_stat,
   input  wire logic [STAMP_BITS-1:0] q_stamp,
   output logic                       q_pop,
   input  wire logic [TOL_W-1:0]      tolerance_ns,
   input  wire logic [WIN_CFG_W-1:0]  window_size,
   output logic                       rsp_valid,
   output logic                       rsp_found,
   output logic [STAMP_BITS-1:0]      rsp_offset_ns,
   output logic                       rsp_out_of_tolerance,
   output logic [31:0]                rsp_pairs_seen,
   output logic [31:0]                rsp_violations_seen,
   output logic [STAMP_BITS-1:0]      rsp_min_offset_ns,
   output logic [STAMP_BITS-1:0]      rsp_max_offset_ns,
   output logic [STAMP_BITS-1:0]      rsp_offset_total_ns
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int ADR_W  = PTR_W + 2;
   localparam int WIN_W  = (FILL_W > WIN_CFG_W) ? FILL_W : WIN_CFG_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_PROBE  = 5'b00010,
      S_CMP    = 5'b00100,
      S_LAST   = 5'b01000,
      S_UPDATE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [STAMP_BITS-1:0] ring_mem [RING_DEPTH];
   logic [STAMP_BITS-1:0] rd_data_ff;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FILL_W-1:0]     first_ff, first_in;
   logic [FILL_W-1:0]     count_ff, count_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [STAMP_BITS-1:0] offset_ff, offset_in;
   logic                  found_ff, found_in;
   logic [31:0]           pairs_ff, pairs_in;
   logic [31:0]           viol_ff, viol_in;
   logic [STAMP_BITS-1:0] min_ff, min_in;
   logic [STAMP_BITS-1:0] max_ff, max_in;
   logic [STAMP_BITS-1:0] sum_ff, sum_in;
   logic                  valid_ff, valid_in;
   logic                  oot_ff, oot_in;

   logic                  ring_we;
   logic [FILL_W-1:0]     step;
   logic [FILL_W-1:0]     win_idx;
   logic [ADR_W-1:0]      adr_sum;
   logic [PTR_W-1:0]      rd_addr;
   logic [WIN_W-1:0]      win_ext;
   logic [WIN_W-1:0]      win_eff;
   logic [FILL_W-1:0]     fill_inc;
   logic [STAMP_BITS:0]   sum_wide;
   logic                  oot_now;

   assign step = count_ff >> 1;

   // Window position to ring slot: oldest kept stamp sits fill slots behind the head.
   always_comb begin
      win_idx = (count_ff == '0) ? first_ff - 1'b1 : first_ff + step;
      adr_sum = ADR_W'(head_ff) + ADR_W'(RING_DEPTH) - ADR_W'(fill_ff) + ADR_W'(win_idx);
      if (adr_sum >= ADR_W'(RING_DEPTH)) begin
         adr_sum = adr_sum - ADR_W'(RING_DEPTH);
      end
      rd_addr = adr_sum[PTR_W-1:0];
   end

   // Effective window: zero acts as one, anything above the ring depth as the depth.
   always_comb begin
      win_ext = WIN_W'(window_size);
      if (win_ext == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_ext > WIN_W'(RING_DEPTH)) begin
         win_eff = WIN_W'(RING_DEPTH);
      end else begin
         win_eff = win_ext;
      end
      fill_inc = (fill_ff < FILL_W'(RING_DEPTH)) ? fill_ff + 1'b1 : fill_ff;
   end

   // Offset statistics for the current match.
   assign sum_wide = {1'b0, sum_ff} + {1'b0, offset_ff};
   assign oot_now  = found_ff && (offset_ff > STAMP_BITS'(tolerance_ns));

   // Sequencer: dispatch, bisection probes, match fetch and statistics update.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      stamp_in  = stamp_ff;
      offset_in = offset_ff;
      found_in  = found_ff;
      pairs_in  = pairs_ff;
      viol_in   = viol_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      oot_in    = oot_ff;
      valid_in  = 1'b0;
      q_pop     = 1'b0;
      ring_we   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_stat.valid) begin
               q_pop = 1'b1;
               if (q_stat.func == FUNC_IMU) begin
                  ring_we = 1'b1;
                  head_in = (head_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  fill_in = (WIN_W'(fill_inc) > win_eff) ? fill_inc - 1'b1 : fill_inc;
               end else begin
                  stamp_in = q_stamp;
                  first_in = '0;
                  count_in = fill_ff;
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (count_ff != '0) begin
               state_in = S_CMP;
            end else if (first_ff != '0) begin
               state_in = S_LAST;
            end else begin
               found_in  = 1'b0;
               offset_in = '0;
               state_in  = S_UPDATE;
            end
         end
         S_CMP: begin
            if (!(stamp_ff < rd_data_ff)) begin
               first_in = first_ff + step + 1'b1;
               count_in = count_ff - step - 1'b1;
            end else begin
               count_in = step;
            end
            state_in = S_PROBE;
         end
         S_LAST: begin
            found_in  = 1'b1;
            offset_in = stamp_ff - rd_data_ff;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            oot_in   = oot_now;
            valid_in = 1'b1;
            if (found_ff) begin
               if (pairs_ff != '1) begin
                  pairs_in = pairs_ff + 1'b1;
               end
               if (oot_now && (viol_ff != '1)) begin
                  viol_in = viol_ff + 1'b1;
               end
               if (offset_ff < min_ff) begin
                  min_in = offset_ff;
               end
               if (offset_ff > max_ff) begin
                  max_in = offset_ff;
               end
               sum_in = sum_wide[STAMP_BITS] ? '1 : sum_wide[STAMP_BITS-1:0];
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and statistics registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         pairs_ff <= '0;
         viol_ff  <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         pairs_ff <= pairs_in;
         viol_ff  <= viol_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   // Search working registers.
   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      count_ff  <= count_in;
      stamp_ff  <= stamp_in;
      offset_ff <= offset_in;
      found_ff  <= found_in;
      oot_ff    <= oot_in;
   end

   // Stamp ring: one write port at the head, one registered read port.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[head_ff] <= q_stamp;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   // Result beat; statistics hold until the next update.
   assign rsp_valid            = valid_ff;
   assign rsp_found            = found_ff;
   assign rsp_offset_ns        = offset_ff;
   assign rsp_out_of_tolerance = oot_ff;
   assign rsp_pairs_seen       = pairs_ff;
   assign rsp_violations_seen  = viol_ff;
   assign rsp_min_offset_ns    = min_ff;
   assign rsp_max_offset_ns    = max_ff;
   assign rsp_offset_total_ns  = sum_ff;

endmodule : tsc_back

`default_nettype wire

@@ sv/timestamp_sync_checker_top.sv @@
// Top level of the timestamp sync checker: configuration registers, front end and back end.
//
//   channel   ports                         handshake
//   event     start, busy, req_*            taken when start is high and busy is low
//   result    rsp_valid, rsp_*              one-cycle strobe, always taken
//   config    csr_valid, csr_ready, csr_*   written when csr_valid and csr_ready
//
// An IMU beat is handled in the back end's dispatch state alone. A camera beat passes through
// the dispatch, then per bisection step a registered ring read plus a compare, the final probe,
// the match read when a stamp matches, and the update; the number of bisection steps is at most
// ceil(log2(fill + 1)), so up to 11 for a 2000-stamp window. The strobe follows in the next
// cycle, alongside the next dispatch.
// A two-entry queue lets the front take beats while the back end searches; busy rises
// only when that queue is full. Reset is synchronous; the ring needs no clearing pass.
// Results cannot be stalled.
`default_nettype none

module timestamp_sync_checker_top
   import tsc_pkg::*;
#(
   parameter int RING_DEPTH = 2048,
   parameter int STAMP_BITS = 63
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_func,
   input  wire logic [STAMP_BITS-1:0] req_stamp_ns,
   output logic                       rsp_valid,
   output logic                       rsp_found,
   output logic [STAMP_BITS-1:0]      rsp_offset_ns,
   output logic                       rsp_out_of_tolerance,
   output logic [31:0]                rsp_pairs_seen,
   output logic [31:0]                rsp_violations_seen,
   output logic [STAMP_BITS-1:0]      rsp_min_offset_ns,
   output logic [STAMP_BITS-1:0]      rsp_max_offset_ns,
   output logic [STAMP_BITS-1:0]      rsp_offset_total_ns,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [TOL_W-1:0]      tol_ff, tol_in;
   logic [WIN_CFG_W-1:0]  win_ff, win_in;
   q_stat_type            q_stat;
   logic [STAMP_BITS-1:0] q_stamp;
   logic                  q_pop;

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      tol_in = tol_ff;
      win_in = win_ff;
      if (csr_valid) begin
         if (csr_index == CSR_TOLERANCE) begin
            tol_in = csr_data[TOL_W-1:0];
         end else if (csr_index == CSR_WINDOW) begin
            win_in = csr_data[WIN_CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         win_ff <= WIN_RESET;
      end else begin
         tol_ff <= tol_in;
         win_ff <= win_in;
      end
   end

   tsc_front #(
      .STAMP_BITS (STAMP_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_stamp_ns (req_stamp_ns),
      .q_pop        (q_pop),
      .q_stat       (q_stat),
      .q_stamp      (q_stamp)
   );

   tsc_back #(
      .RING_DEPTH (RING_DEPTH),
      .STAMP_BITS (STAMP_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_stat               (q_stat),
      .q_stamp              (q_stamp),
      .q_pop                (q_pop),
      .tolerance_ns         (tol_ff),
      .window_size          (win_ff),
      .rsp_valid            (rsp_valid),
      .rsp_found            (rsp_found),
      .rsp_offset_ns        (rsp_offset_ns),
      .rsp_out_of_tolerance (rsp_out_of_tolerance),
      .rsp_pairs_seen       (rsp_pairs_seen),
      .rsp_violations_seen  (rsp_violations_seen),
      .rsp_min_offset_ns    (rsp_min_offset_ns),
      .rsp_max_offset_ns    (rsp_max_offset_ns),
      .rsp_offset_total_ns  (rsp_offset_total_ns)
   );

endmodule : timestamp_sync_checker_top

`default_nettype wire
